@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define DDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define DDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define DDA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define DDA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/dda_pkg.sv @@
package dda_pkg;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 16;
    localparam int COLOR_BITS = 32;
    localparam int ADDR_BITS  = 24;
    localparam int DIM_BITS   = 13;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 3;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int MAG_BITS   = COORD_BITS;
    localparam int REM_BITS   = MAG_BITS + 1;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int INC_BITS   = FRAC_BITS + 2;
    localparam int CNT_BITS   = $clog2(QUOT_BITS + 1);
    localparam int LEFT_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = COORD_BITS + DIM_BITS;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(480);

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic finish;
        logic advance;
        logic emit;
    } dda_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last;
    } dda_status_t;

endpackage

@@ rtl/dda_cmd_if.sv @@
interface dda_cmd_if;
    import dda_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        color;

    modport source (output valid, op, start_x, start_y, end_x, end_y, color, input ready);
    modport sink (input valid, op, start_x, start_y, end_x, end_y, color, output ready);
endinterface

@@ rtl/dda_pix_if.sv @@
interface dda_pix_if;
    import dda_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]         address;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         visible;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, address, pixel_color, visible, last,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, address, pixel_color, visible, last,
                  output ready);
endinterface

@@ rtl/dda_cfg_if.sv @@
interface dda_cfg_if;
    import dda_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DIM_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/dda_ctrl.sv @@
module dda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_op,
    output logic                cmd_ready,
    input  logic                pix_ready,
    output logic                pix_valid,
    input  dda_pkg::dda_status_t status,
    output dda_pkg::dda_cmd_t    ctl
);
    import dda_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_LINE = 5'b00100,
        S_PIX  = 5'b01000,
        S_ADDR = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pix_valid_reg;
    logic   pix_valid_next;
    logic   accept;
    logic   out_free;

    assign cmd_ready = (state_reg == S_IDLE) || (state_reg == S_LINE);
    assign accept    = cmd_valid && cmd_ready;
    assign out_free  = !pix_valid_reg || pix_ready;
    assign pix_valid = pix_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.load     = accept && (cmd_op == OP_LOAD);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_op == OP_LOAD))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_LINE;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            S_LINE:
            begin
                if (accept)
                begin
                    state_next = (cmd_op == OP_LOAD) ? S_DIV : S_PIX;
                end
            end
            S_PIX:
            begin
                ctl.advance = 1'b1;
                state_next  = S_ADDR;
            end
            S_ADDR:
            begin
                if (out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = status.last ? S_IDLE : S_LINE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (ctl.emit)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_valid_reg <= pix_valid_next;
        end
    end
endmodule

@@ rtl/dda_datapath.sv @@
module dda_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dda_pkg::dda_cmd_t                     ctl,
    output dda_pkg::dda_status_t                  status,
    input  logic signed [dda_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [dda_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [dda_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [dda_pkg::COORD_BITS-1:0] end_y,
    input  logic [dda_pkg::COLOR_BITS-1:0]        color,
    input  logic                                  cfg_write,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [dda_pkg::DIM_BITS-1:0]          cfg_data,
    output logic signed [dda_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [dda_pkg::COORD_BITS-1:0] pixel_y,
    output logic [dda_pkg::ADDR_BITS-1:0]         address,
    output logic [dda_pkg::COLOR_BITS-1:0]        pixel_color,
    output logic                                  visible,
    output logic                                  last
);
    import dda_pkg::*;

    logic [DIM_BITS-1:0]          fw_reg;
    logic [DIM_BITS-1:0]          fh_reg;
    logic signed [POS_BITS-1:0]   pos_x_reg;
    logic signed [POS_BITS-1:0]   pos_y_reg;
    logic signed [INC_BITS-1:0]   inc_x_reg;
    logic signed [INC_BITS-1:0]   inc_y_reg;
    logic [LEFT_BITS-1:0]         left_reg;
    logic [COLOR_BITS-1:0]        color_reg;
    logic                         neg_x_reg;
    logic                         neg_y_reg;
    logic                         zero_reg;
    logic [REM_BITS-1:0]          rem_x_reg;
    logic [REM_BITS-1:0]          rem_y_reg;
    logic [QUOT_BITS-1:0]         quo_x_reg;
    logic [QUOT_BITS-1:0]         quo_y_reg;
    logic [MAG_BITS-1:0]          divisor_reg;
    logic [CNT_BITS-1:0]          cnt_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic                         last_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic [ADDR_BITS-1:0]         out_addr_reg;
    logic [COLOR_BITS-1:0]        out_color_reg;
    logic                         out_vis_reg;
    logic                         out_last_reg;

    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic [DELTA_BITS-1:0]        abs_dx;
    logic [DELTA_BITS-1:0]        abs_dy;
    logic [MAG_BITS-1:0]          mag_x;
    logic [MAG_BITS-1:0]          mag_y;
    logic [MAG_BITS-1:0]          steps;
    logic                         ge_x;
    logic                         ge_y;
    logic [REM_BITS-1:0]          diff_x;
    logic [REM_BITS-1:0]          diff_y;
    logic [REM_BITS-1:0]          div_ext;
    logic [INC_BITS-1:0]          quo_x_ext;
    logic [INC_BITS-1:0]          quo_y_ext;
    logic signed [POS_BITS-1:0]   bias_x;
    logic signed [POS_BITS-1:0]   bias_y;
    logic signed [POS_BITS-1:0]   trunc_x;
    logic signed [POS_BITS-1:0]   trunc_y;
    logic [PROD_BITS-1:0]         row_base;
    logic [PROD_BITS-1:0]         lin_addr;
    logic                         vis;

    // line setup
    assign dx     = DELTA_BITS'(end_x) - DELTA_BITS'(start_x);
    assign dy     = DELTA_BITS'(end_y) - DELTA_BITS'(start_y);
    assign abs_dx = dx[DELTA_BITS-1] ? -dx : dx;
    assign abs_dy = dy[DELTA_BITS-1] ? -dy : dy;
    assign mag_x  = abs_dx[MAG_BITS-1:0];
    assign mag_y  = abs_dy[MAG_BITS-1:0];
    assign steps  = (mag_x >= mag_y) ? mag_x : mag_y;

    // restoring divider, one quotient bit per cycle on each axis
    assign div_ext = {1'b0, divisor_reg};
    assign ge_x    = rem_x_reg >= div_ext;
    assign ge_y    = rem_y_reg >= div_ext;
    assign diff_x  = ge_x ? (rem_x_reg - div_ext) : rem_x_reg;
    assign diff_y  = ge_y ? (rem_y_reg - div_ext) : rem_y_reg;
    assign quo_x_ext = {1'b0, quo_x_reg};
    assign quo_y_ext = {1'b0, quo_y_reg};

    // position to integer, truncated toward zero
    assign bias_x  = pos_x_reg[POS_BITS-1] ? POS_BITS'((1 << FRAC_BITS) - 1) : '0;
    assign bias_y  = pos_y_reg[POS_BITS-1] ? POS_BITS'((1 << FRAC_BITS) - 1) : '0;
    assign trunc_x = pos_x_reg + bias_x;
    assign trunc_y = pos_y_reg + bias_y;

    // clipping and linear address
    assign vis = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
              && (DIM_BITS'(cur_x_reg) < fw_reg) && (DIM_BITS'(cur_y_reg) < fh_reg);
    assign row_base = PROD_BITS'(cur_y_reg[COORD_BITS-2:0]) * PROD_BITS'(fw_reg);
    assign lin_addr = row_base + PROD_BITS'(cur_x_reg[COORD_BITS-2:0]);

    assign status.div_done = (cnt_reg == '0);
    assign status.last     = last_reg;

    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign address     = out_addr_reg;
    assign pixel_color = out_color_reg;
    assign visible     = out_vis_reg;
    assign last        = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FRAME_WIDTH_RESET;
            fh_reg  <= FRAME_HEIGHT_RESET;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default:          fw_reg <= fw_reg;
                endcase
            end
            if (ctl.load)
            begin
                cnt_reg <= CNT_BITS'(QUOT_BITS);
            end
            else if (ctl.div_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_x_reg   <= REM_BITS'(mag_x);
            rem_y_reg   <= REM_BITS'(mag_y);
            quo_x_reg   <= '0;
            quo_y_reg   <= '0;
            divisor_reg <= steps;
            zero_reg    <= (steps == '0);
            neg_x_reg   <= dx[DELTA_BITS-1];
            neg_y_reg   <= dy[DELTA_BITS-1];
            pos_x_reg   <= POS_BITS'(start_x) <<< FRAC_BITS;
            pos_y_reg   <= POS_BITS'(start_y) <<< FRAC_BITS;
            left_reg    <= LEFT_BITS'(steps) + 1'b1;
            color_reg   <= color;
        end
        else if (ctl.advance)
        begin
            pos_x_reg <= pos_x_reg + POS_BITS'(inc_x_reg);
            pos_y_reg <= pos_y_reg + POS_BITS'(inc_y_reg);
            left_reg  <= left_reg - 1'b1;
        end
        if (ctl.div_step)
        begin
            quo_x_reg <= {quo_x_reg[QUOT_BITS-2:0], ge_x};
            quo_y_reg <= {quo_y_reg[QUOT_BITS-2:0], ge_y};
            rem_x_reg <= {diff_x[REM_BITS-2:0], 1'b0};
            rem_y_reg <= {diff_y[REM_BITS-2:0], 1'b0};
        end
        if (ctl.finish)
        begin
            inc_x_reg <= zero_reg ? '0 : (neg_x_reg ? -quo_x_ext : quo_x_ext);
            inc_y_reg <= zero_reg ? '0 : (neg_y_reg ? -quo_y_ext : quo_y_ext);
        end
        if (ctl.advance)
        begin
            cur_x_reg <= trunc_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            cur_y_reg <= trunc_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            last_reg  <= (left_reg == LEFT_BITS'(1));
        end
        if (ctl.emit)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_addr_reg  <= vis ? lin_addr[ADDR_BITS-1:0] : '0;
            out_color_reg <= color_reg;
            out_vis_reg   <= vis;
            out_last_reg  <= last_reg;
        end
    end
endmodule

@@ rtl/dda_line_rasterizer_unit.sv @@
// dda line rasterizer: load item latches a line, each step item during a line yields one pixel
// load: input blocked while the 17-iteration restoring divider runs, no transaction out
// step: passes S_PIX, then S_ADDR, which waits until the pixel output register is free
// the next step is taken only after the pixel is emitted; a step with no line is accepted and dropped
// reset: async active low; idle, no line, frame 640x480, no pixel pending
`include "assert_macros.svh"

module dda_line_rasterizer_unit (
    input  logic  clk,
    input  logic  rst_n,
    dda_cmd_if.sink   cmd,
    dda_pix_if.source pix,
    dda_cfg_if.sink   cfg
);
    import dda_pkg::*;

    dda_cmd_t    ctl;
    dda_status_t status;
    logic        cmd_fire;
    logic        pix_neg;

    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign pix_neg   = pix.pixel_x[COORD_BITS-1] || pix.pixel_y[COORD_BITS-1];

    dda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_op    (cmd.op),
        .cmd_ready (cmd.ready),
        .pix_ready (pix.ready),
        .pix_valid (pix.valid),
        .status    (status),
        .ctl       (ctl)
    );

    dda_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .start_x     (cmd.start_x),
        .start_y     (cmd.start_y),
        .end_x       (cmd.end_x),
        .end_y       (cmd.end_y),
        .color       (cmd.color),
        .cfg_write   (cfg.valid && cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .pixel_x     (pix.pixel_x),
        .pixel_y     (pix.pixel_y),
        .address     (pix.address),
        .pixel_color (pix.pixel_color),
        .visible     (pix.visible),
        .last        (pix.last)
    );

    `DDA_ASSERT_NXT(a_load_busy, clk, rst_n, cmd_fire && (cmd.op == OP_LOAD), !cmd.ready)
    `DDA_ASSERT_IMP(a_hidden_addr, clk, rst_n, pix.valid && !pix.visible, pix.address == '0)
    `DDA_ASSERT_IMP(a_visible_pos, clk, rst_n, pix.valid && pix.visible, !pix_neg)
    `DDA_ASSERT_NXT(a_pix_hold, clk, rst_n, pix.valid && !pix.ready, pix.valid && $stable(pix.address))
endmodule

@@ bench/tb_dda_line_rasterizer_unit.sv @@
module tb_dda_line_rasterizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_CAP     = 50;
    localparam int COORD_MIN     = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;

    typedef struct {
        logic                         op;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0]        color;
    } cmd_item_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [ADDR_BITS-1:0]         address;
        logic [COLOR_BITS-1:0]        pixel_color;
        logic                         visible;
        logic                         last;
    } pixel_t;

    class line_tracer;
        longint   pos_x;
        longint   pos_y;
        longint   inc_x;
        longint   inc_y;
        longint   pixels_left;
        logic [COLOR_BITS-1:0] line_color;
        bit       drawing;
        longint   width;
        longint   height;
        pixel_t   expected_pixels[$];
        int       mismatches;
        int       counted_items;
        int       checked;

        function new();
            width         = longint'(FRAME_WIDTH_RESET);
            height        = longint'(FRAME_HEIGHT_RESET);
            pos_x         = 0;
            pos_y         = 0;
            inc_x         = 0;
            inc_y         = 0;
            pixels_left   = 0;
            line_color    = '0;
            drawing       = 1'b0;
            mismatches    = 0;
            counted_items = 0;
            checked       = 0;
        endfunction

        function longint magnitude(input longint v);
            return (v < 0) ? -v : v;
        endfunction

        // fixed-point slope, truncated toward zero
        function longint slope(input longint delta, input longint span);
            longint mag;
            mag = (magnitude(delta) << FRAC_BITS) / span;
            return (delta < 0) ? -mag : mag;
        endfunction

        function longint whole_part(input longint p);
            longint mag;
            mag = magnitude(p) >> FRAC_BITS;
            return (p < 0) ? -mag : mag;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void set_register(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [DIM_BITS-1:0] value);
            if (idx == CFG_FRAME_WIDTH)
                width = longint'(value);
            else if (idx == CFG_FRAME_HEIGHT)
                height = longint'(value);
        endfunction

        function void note_command(input cmd_item_t c);
            longint sx;
            longint sy;
            longint dx;
            longint dy;
            longint span;
            longint x;
            longint y;
            bit     vis;
            pixel_t p;
            if (c.op == OP_LOAD)
            begin
                sx   = longint'(c.start_x);
                sy   = longint'(c.start_y);
                dx   = longint'(c.end_x) - sx;
                dy   = longint'(c.end_y) - sy;
                span = (magnitude(dx) >= magnitude(dy)) ? magnitude(dx) : magnitude(dy);
                if (span == 0)
                begin
                    inc_x = 0;
                    inc_y = 0;
                end
                else
                begin
                    inc_x = slope(dx, span);
                    inc_y = slope(dy, span);
                end
                pos_x         = sx * (longint'(1) << FRAC_BITS);
                pos_y         = sy * (longint'(1) << FRAC_BITS);
                pixels_left   = span + 1;
                line_color    = c.color;
                drawing       = 1'b1;
                counted_items++;
            end
            else if (drawing)
            begin
                x   = whole_part(pos_x);
                y   = whole_part(pos_y);
                vis = (x >= 0) && (y >= 0) && (x < width) && (y < height);
                p.pixel_x     = COORD_BITS'(x);
                p.pixel_y     = COORD_BITS'(y);
                p.address     = vis ? ADDR_BITS'(y * width + x) : '0;
                p.pixel_color = line_color;
                p.visible     = vis;
                pos_x         = pos_x + inc_x;
                pos_y         = pos_y + inc_y;
                pixels_left--;
                if (pixels_left == 0)
                    drawing = 1'b0;
                p.last = !drawing;
                expected_pixels.push_back(p);
                counted_items++;
            end
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("mismatch at pixel %0d: %s", checked, what);
        endtask

        task check_pixel(input pixel_t got);
            pixel_t want;
            checked++;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel (%0d,%0d)",
                                          got.pixel_x, got.pixel_y));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x)
                report_mismatch($sformatf("pixel_x got %0d want %0d",
                                          got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report_mismatch($sformatf("pixel_y got %0d want %0d",
                                          got.pixel_y, want.pixel_y));
            if (got.address !== want.address)
                report_mismatch($sformatf("address got %0h want %0h",
                                          got.address, want.address));
            if (got.pixel_color !== want.pixel_color)
                report_mismatch($sformatf("pixel_color got %0h want %0h",
                                          got.pixel_color, want.pixel_color));
            if (got.visible !== want.visible)
                report_mismatch($sformatf("visible got %b want %b",
                                          got.visible, want.visible));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %b want %b", got.last, want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dda_cmd_if cmd_bus ();
    dda_pix_if pix_bus ();
    dda_cfg_if cfg_bus ();

    dda_line_rasterizer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus),
        .cfg   (cfg_bus)
    );

    line_tracer tracer = new();

    int     send_idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_toggle = 1'b0;
    bit     hold_seen = 1'b0;
    int     hold_left = 0;
    int     frame_w = int'(FRAME_WIDTH_RESET);
    int     frame_h = int'(FRAME_HEIGHT_RESET);
    pixel_t seen_pixel;
    cmd_item_t seen_cmd;

    int phase_width[8]  = '{8191, 640, 0, 1, 32, 4096, 4096, 13};
    int phase_height[8] = '{8191, 480, 0, 1, 24, 4096, 1, 8191};
    int phase_send[4]   = '{0, 79, 0, 24};
    int phase_stall[4]  = '{0, 0, 79, 24};

    always #2 clk = ~clk;

    // pixel transaction is checked first, then command and register transactions are noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_bus.valid && pix_bus.ready)
            begin
                seen_pixel.pixel_x     = pix_bus.pixel_x;
                seen_pixel.pixel_y     = pix_bus.pixel_y;
                seen_pixel.address     = pix_bus.address;
                seen_pixel.pixel_color = pix_bus.pixel_color;
                seen_pixel.visible     = pix_bus.visible;
                seen_pixel.last        = pix_bus.last;
                tracer.check_pixel(seen_pixel);
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                seen_cmd.op      = cmd_bus.op;
                seen_cmd.start_x = cmd_bus.start_x;
                seen_cmd.start_y = cmd_bus.start_y;
                seen_cmd.end_x   = cmd_bus.end_x;
                seen_cmd.end_y   = cmd_bus.end_y;
                seen_cmd.color   = cmd_bus.color;
                tracer.note_command(seen_cmd);
            end
            if (cfg_bus.valid && cfg_bus.ready)
                tracer.set_register(cfg_bus.index, cfg_bus.data);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        pix_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_bus.ready <= 1'b0;
            end
            else
                pix_bus.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic cmd_item_t make_load(input int sx, input int sy, input int ex,
                                            input int ey, input logic [COLOR_BITS-1:0] c);
        cmd_item_t item;
        item.op      = OP_LOAD;
        item.start_x = COORD_BITS'(sx);
        item.start_y = COORD_BITS'(sy);
        item.end_x   = COORD_BITS'(ex);
        item.end_y   = COORD_BITS'(ey);
        item.color   = c;
        return item;
    endfunction

    // step fields are ignored by the block but still toggled
    function automatic cmd_item_t make_step();
        cmd_item_t item;
        item.op      = OP_STEP;
        item.start_x = COORD_BITS'($urandom());
        item.start_y = COORD_BITS'($urandom());
        item.end_x   = COORD_BITS'($urandom());
        item.end_y   = COORD_BITS'($urandom());
        item.color   = $urandom();
        return item;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int rand_coord(input int dim);
        if ($urandom_range(0, 2) == 0)
            return int'($urandom_range(0, 8191)) - 4096;
        return clamp_coord(int'($urandom_range(0, dim + 8)) - 4);
    endfunction

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic send_command(input cmd_item_t c);
        while (int'($urandom_range(0, 99)) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.op      <= c.op;
        cmd_bus.start_x <= c.start_x;
        cmd_bus.start_y <= c.start_y;
        cmd_bus.end_x   <= c.end_x;
        cmd_bus.end_y   <= c.end_y;
        cmd_bus.color   <= c.color;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    task automatic send_steps(input int count);
        repeat (count) send_command(make_step());
    endtask

    // waits on the clock first so the last accepted command has been noted
    task automatic wait_for_drain();
        @(posedge clk);
        while (tracer.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cmd_bus.valid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= DIM_BITS'(value);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            frame_w = value;
        else
            frame_h = value;
    endtask

    task automatic run_directed();
        send_steps(1);
        send_command(make_load(0, 0, 0, 0, 32'h0000_0000));
        send_steps(2);
        send_command(make_load(639, 479, 640, 480, 32'hFFFF_FFFF));
        send_steps(2);
        send_command(make_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hA5A5_5A5A));
        send_steps(2);
        send_command(make_load(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 32'h5A5A_A5A5));
        send_steps(1);
        send_command(make_load(0, 0, 3, -2, 32'h1234_5678));
        send_steps(4);
        send_command(make_load(5, 1, 2, 7, 32'h8765_4321));
        send_steps(7);
    endtask

    task automatic run_random_lines(input int budget);
        int target;
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int count;
        int pick;
        cmd_item_t noise;
        target = tracer.counted_items + budget;
        while (tracer.counted_items < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                noise = make_step();
                noise.op = 1'($urandom_range(0, 1));
                send_command(noise);
            end
            else
            begin
                sx = rand_coord(frame_w);
                sy = rand_coord(frame_h);
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
                    ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
                end
                else if (pick < 95)
                begin
                    ex = clamp_coord(sx + int'($urandom_range(0, 300)) - 150);
                    ey = clamp_coord(sy + int'($urandom_range(0, 300)) - 150);
                end
                else
                begin
                    ex = int'($urandom_range(0, 8191)) - 4096;
                    ey = int'($urandom_range(0, 8191)) - 4096;
                end
                span = (abs_int(ex - sx) >= abs_int(ey - sy)) ? abs_int(ex - sx)
                                                              : abs_int(ey - sy);
                send_command(make_load(sx, sy, ex, ey, $urandom()));
                pick = $urandom_range(0, 99);
                if (span > 40)
                    count = $urandom_range(1, 30);
                else if (pick < 75)
                    count = span + 1;
                else if (pick < 88)
                    count = $urandom_range(0, span);
                else
                    count = span + 1 + int'($urandom_range(1, 3));
                send_steps(count);
            end
        end
    endtask

    initial
    begin
        cmd_bus.valid   <= 1'b0;
        cmd_bus.op      <= OP_LOAD;
        cmd_bus.start_x <= '0;
        cmd_bus.start_y <= '0;
        cmd_bus.end_x   <= '0;
        cmd_bus.end_y   <= '0;
        cmd_bus.color   <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= CFG_FRAME_WIDTH;
        cfg_bus.data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 4; phase++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                write_register(CFG_FRAME_WIDTH, phase_width[2 * phase + half]);
                write_register(CFG_FRAME_HEIGHT, phase_height[2 * phase + half]);
                send_idle_pct = phase_send[phase];
                stall_pct     = phase_stall[phase];
                if (phase == 0 && half == 0)
                begin
                    // long receiver hold-off while the sender keeps offering
                    hold_toggle = ~hold_toggle;
                    send_command(make_load(-60, 10, 60, -20, $urandom()));
                    send_steps(121);
                end
                run_random_lines(65);
            end
        end

        cmd_bus.valid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracer.mismatches == 0 && tracer.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
